### hw/rtl/rgbaob_pkg.sv
// Shared constants and types for the RGBA over-blend unit.
package rgbaob_pkg;

  // Full-scale channel and alpha value
  localparam logic [7:0] FULL_SCALE = 8'd255;

  // Number of color channels blended (red, green, blue)
  localparam int unsigned NUM_CH = 3;

  // Exact x/255 by reciprocal multiply: 16-bit and 24-bit operands
  localparam logic [15:0] DIV255_M16 = 16'h8081;
  localparam int unsigned DIV255_S16 = 23;
  localparam logic [23:0] DIV255_M24 = 24'h808081;
  localparam int unsigned DIV255_S24 = 31;

  // Channel numerator width (top*a_src + ground term < 2^17)
  localparam int unsigned NUM_W = 17;
  // Reciprocal table: floor(2^NUM_W / den)
  localparam int unsigned RECIP_SHIFT = NUM_W;
  localparam int unsigned REC_W = NUM_W + 1;

  // One input pixel pair plus intensity
  typedef struct packed {
    logic [7:0] top_red;
    logic [7:0] top_green;
    logic [7:0] top_blue;
    logic [7:0] top_alpha;
    logic [7:0] ground_red;
    logic [7:0] ground_green;
    logic [7:0] ground_blue;
    logic [7:0] ground_alpha;
    logic [7:0] intensity;
  } pix_t;

  // Special-case flags that ride along the pipeline
  typedef struct packed {
    logic clear;   // effective source alpha is zero
    logic opaque;  // source and ground both fully opaque
  } flag_t;

  // Stage load enables for the divider pipeline
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } div_en_t;

endpackage

### hw/rtl/rgbaob_if.sv
// Valid/ready channel interfaces for the RGBA over-blend unit.
interface rgbaob_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] top_red;
  logic [7:0] top_green;
  logic [7:0] top_blue;
  logic [7:0] top_alpha;
  logic [7:0] ground_red;
  logic [7:0] ground_green;
  logic [7:0] ground_blue;
  logic [7:0] ground_alpha;
  logic [7:0] intensity;

  modport source (
    output valid, top_red, top_green, top_blue, top_alpha,
           ground_red, ground_green, ground_blue, ground_alpha, intensity,
    input  ready
  );
  modport sink (
    input  valid, top_red, top_green, top_blue, top_alpha,
           ground_red, ground_green, ground_blue, ground_alpha, intensity,
    output ready
  );
endinterface

interface rgbaob_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha,
    output ready
  );
endinterface

### hw/rtl/rgbaob_div.sv
// Three-stage pipelined 17-by-8 bit divider with saturation to 8 bits.
module rgbaob_div import rgbaob_pkg::*; (
  input  logic             clk_i,
  input  div_en_t          en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [7:0]       den_i,
  output logic [7:0]       quot_o
);

  // Reciprocal table, built at elaboration; entry 0 unused (guarded upstream)
  logic [REC_W-1:0] recip_tab [256];

  for (genvar gi = 0; gi < 256; gi++) begin : g_rec
    localparam logic [REC_W-1:0] RecipVal =
      (gi == 0) ? '0 : REC_W'((1 << RECIP_SHIFT) / ((gi == 0) ? 1 : gi));
    assign recip_tab[gi] = RecipVal;
  end

  logic [NUM_W-1:0]       num1_q, num2_q, num3_q;
  logic [7:0]             den1_q, den2_q, den3_q;
  logic [REC_W-1:0]       rec1_q;
  logic [NUM_W-1:0]       q0_2_q, q0_3_q;
  logic [NUM_W-1:0]       q0a_3_q;
  logic [NUM_W+REC_W-1:0] prod;
  logic [NUM_W+7:0]       q0a_full;
  logic [NUM_W-1:0]       rem;
  logic [NUM_W:0]         quot;

  // Stage 1: reciprocal lookup
  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      num1_q <= num_i;
      den1_q <= den_i;
      rec1_q <= recip_tab[den_i];
    end
  end

  // Stage 2: estimate, low by at most one
  assign prod = num1_q * rec1_q;

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      q0_2_q <= prod[RECIP_SHIFT +: NUM_W];
      num2_q <= num1_q;
      den2_q <= den1_q;
    end
  end

  // Stage 3: back-multiply for the remainder check
  assign q0a_full = q0_2_q * den2_q;

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      q0a_3_q <= q0a_full[NUM_W-1:0];
      q0_3_q  <= q0_2_q;
      num3_q  <= num2_q;
      den3_q  <= den2_q;
    end
  end

  // Correction and saturation
  always_comb begin
    rem  = num3_q - q0a_3_q;
    quot = {1'b0, q0_3_q} + ((rem >= {{(NUM_W-8){1'b0}}, den3_q}) ? 1'b1 : 1'b0);
    quot_o = (quot > {{(NUM_W-7){1'b0}}, FULL_SCALE}) ? FULL_SCALE : quot[7:0];
  end

endmodule

### hw/rtl/rgba_over_blend_intensity_unit.sv
// Top level of the RGBA over-blend unit with intensity-scaled source alpha.
//
// Porter-Duff "over" of a non-premultiplied 8-bit RGBA top pixel onto a
// ground pixel, the top alpha first scaled by intensity/255. One pixel is
// accepted per clock when the output side is not stalled. The datapath
// is ten register stages: alpha scaling, the divide-by-255 reciprocal
// multiplies, the ground-term products, and a three-stage reciprocal-table
// divider for the final channel quotients, with each multiply followed by
// a register. Every stage holds its own valid bit, so empty stages fill in
// while the output waits and a stall drops or repeats nothing.
module rgba_over_blend_intensity_unit import rgbaob_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  rgbaob_in_if.sink     in_i,
  rgbaob_out_if.source  out_o
);

  localparam int unsigned NSTG = 10;

  logic [NSTG-1:0] v_q;
  logic [NSTG-1:0] en;

  // Stage load enables: a stage loads when empty or when the next one moves
  always_comb begin
    en[NSTG-1] = !v_q[NSTG-1] || out_o.ready;
    for (int k = NSTG-2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_i.ready = en[0];

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_i.valid;
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Pixel side channel through the pipe
  pix_t px_in;
  pix_t px_q [9];

  assign px_in = '{top_red:      in_i.top_red,
                   top_green:    in_i.top_green,
                   top_blue:     in_i.top_blue,
                   top_alpha:    in_i.top_alpha,
                   ground_red:   in_i.ground_red,
                   ground_green: in_i.ground_green,
                   ground_blue:  in_i.ground_blue,
                   ground_alpha: in_i.ground_alpha,
                   intensity:    in_i.intensity};

  always_ff @(posedge clk_i) begin
    if (en[0]) px_q[0] <= px_in;
    for (int k = 1; k < 9; k++) begin
      if (en[k]) px_q[k] <= px_q[k-1];
    end
  end

  // Stage 0: top alpha times intensity
  logic [15:0] psrc_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) psrc_q <= in_i.top_alpha * in_i.intensity;
  end

  // Stage 1: effective source alpha = product / 255
  logic [31:0] psrc_m;
  logic [7:0]  asrc_q;

  assign psrc_m = psrc_q * DIV255_M16;

  always_ff @(posedge clk_i) begin
    if (en[1]) asrc_q <= psrc_m[DIV255_S16 +: 8];
  end

  // Stage 2: inverse alpha, per-channel products, special-case flags
  logic [7:0]  inv;
  logic [7:0]  top_c [NUM_CH];
  logic [7:0]  gnd_c [NUM_CH];
  logic [15:0] ts2_q [NUM_CH];
  logic [15:0] gp2_q [NUM_CH];
  logic [15:0] gai2_q;
  logic [7:0]  inv2_q;
  flag_t       fl_q [2:8];

  always_comb begin
    inv      = FULL_SCALE - asrc_q;
    top_c[0] = px_q[1].top_red;
    top_c[1] = px_q[1].top_green;
    top_c[2] = px_q[1].top_blue;
    gnd_c[0] = px_q[1].ground_red;
    gnd_c[1] = px_q[1].ground_green;
    gnd_c[2] = px_q[1].ground_blue;
  end

  // Flags are set here and then ride along to the output stage
  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      for (int c = 0; c < NUM_CH; c++) begin
        ts2_q[c] <= top_c[c] * asrc_q;
        gp2_q[c] <= gnd_c[c] * px_q[1].ground_alpha;
      end
      gai2_q <= px_q[1].ground_alpha * inv;
      inv2_q <= inv;
      fl_q[2].clear  <= (asrc_q == '0);
      fl_q[2].opaque <= (asrc_q == FULL_SCALE) && (px_q[1].ground_alpha == FULL_SCALE);
    end
    for (int k = 3; k < 9; k++) begin
      if (en[k]) fl_q[k] <= fl_q[k-1];
    end
  end

  // Stage 3: ground term times inverse alpha, alpha term reciprocal multiply
  logic [23:0] gpi3_q [NUM_CH];
  logic [15:0] ts3_q  [NUM_CH];
  logic [31:0] aq3_q;
  logic [7:0]  inv3_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      for (int c = 0; c < NUM_CH; c++) begin
        gpi3_q[c] <= gp2_q[c] * inv2_q;
        ts3_q[c]  <= ts2_q[c];
      end
      aq3_q  <= gai2_q * DIV255_M16;
      inv3_q <= inv2_q;
    end
  end

  // Stage 4: output alpha and ground terms divided by 255
  logic [47:0] gq_m  [NUM_CH];
  logic [8:0]  asum;
  logic [15:0] gq4_q [NUM_CH];
  logic [15:0] ts4_q [NUM_CH];
  logic [7:0]  aout_q [4:8];

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      gq_m[c] = gpi3_q[c] * DIV255_M24;
    end
    asum = {1'b0, FULL_SCALE - inv3_q} + {1'b0, aq3_q[DIV255_S16 +: 8]};
  end

  // Output alpha is formed here and then delayed to the output stage
  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      for (int c = 0; c < NUM_CH; c++) begin
        gq4_q[c] <= gq_m[c][DIV255_S24 +: 16];
        ts4_q[c] <= ts3_q[c];
      end
      aout_q[4] <= (asum > {1'b0, FULL_SCALE}) ? FULL_SCALE : asum[7:0];
    end
    for (int k = 5; k < 9; k++) begin
      if (en[k]) aout_q[k] <= aout_q[k-1];
    end
  end

  // Stage 5: channel numerators
  logic [NUM_W-1:0] num5_q [NUM_CH];

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      for (int c = 0; c < NUM_CH; c++) begin
        num5_q[c] <= {1'b0, ts4_q[c]} + {1'b0, gq4_q[c]};
      end
    end
  end

  // Stages 6 to 8: numerator / output alpha, one divider per channel
  div_en_t    div_en;
  logic [7:0] quot [NUM_CH];

  assign div_en = '{s1: en[6], s2: en[7], s3: en[8]};

  for (genvar gc = 0; gc < NUM_CH; gc++) begin : g_div
    rgbaob_div u_div (
      .clk_i  (clk_i),
      .en_i   (div_en),
      .num_i  (num5_q[gc]),
      .den_i  (aout_q[5]),
      .quot_o (quot[gc])
    );
  end

  // Stage 9: pick special case or blended result into the output register
  logic [7:0] red_q, green_q, blue_q, alpha_q;

  always_ff @(posedge clk_i) begin
    if (en[9]) begin
      if (fl_q[8].clear || (!fl_q[8].opaque && aout_q[8] == '0)) begin
        red_q   <= px_q[8].ground_red;
        green_q <= px_q[8].ground_green;
        blue_q  <= px_q[8].ground_blue;
        alpha_q <= px_q[8].ground_alpha;
      end else if (fl_q[8].opaque) begin
        red_q   <= px_q[8].top_red;
        green_q <= px_q[8].top_green;
        blue_q  <= px_q[8].top_blue;
        alpha_q <= px_q[8].top_alpha;
      end else begin
        red_q   <= quot[0];
        green_q <= quot[1];
        blue_q  <= quot[2];
        alpha_q <= aout_q[8];
      end
    end
  end

  assign out_o.valid     = v_q[NSTG-1];
  assign out_o.out_red   = red_q;
  assign out_o.out_green = green_q;
  assign out_o.out_blue  = blue_q;
  assign out_o.out_alpha = alpha_q;

endmodule

### sim/tb.sv
// Self-checking testbench for the RGBA over-blend unit with intensity-scaled source alpha.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rgbaob_pkg::*;

  localparam int unsigned SCALE = FULL_SCALE;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned RANDOM_ITEMS = 450;
  localparam int unsigned IDLE_PCT = 29;
  localparam int unsigned TAIL_CYCLES = 30;

  // One composited pixel as it leaves the block
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  // Holds predicted pixels in issue order and checks results against them
  class blend_scoreboard;
    rgba_t       expected_pixels[$];
    int unsigned errors;
    int unsigned checked;

    function new();
      errors  = 0;
      checked = 0;
    endfunction

    // One color channel: blended numerator over output alpha, saturated
    function int unsigned mix_channel(int unsigned t, int unsigned g, int unsigned a_src,
                                      int unsigned ga, int unsigned inv, int unsigned a_out);
      int unsigned num;
      int unsigned q;
      num = t * a_src + (g * ga * inv) / SCALE;
      q   = num / a_out;
      return (q > SCALE) ? SCALE : q;
    endfunction

    // Over-composite of one pixel pair
    function rgba_t blend_over(pix_t p);
      int unsigned ta, ga, it;
      int unsigned a_src, inv, a_out;
      rgba_t       r;
      rgba_t       ground;
      ta = p.top_alpha;
      ga = p.ground_alpha;
      it = p.intensity;
      ground = '{p.ground_red, p.ground_green, p.ground_blue, p.ground_alpha};
      a_src = (ta * it) / SCALE;
      // transparent source keeps the ground pixel
      if (a_src == 0) return ground;
      // both fully opaque: top wins outright
      if (a_src == SCALE && ga == SCALE)
        return '{p.top_red, p.top_green, p.top_blue, p.top_alpha};
      inv   = SCALE - a_src;
      a_out = a_src + (ga * inv) / SCALE;
      if (a_out > SCALE) a_out = SCALE;
      if (a_out == 0) return ground;
      r.red   = 8'(mix_channel(p.top_red,   p.ground_red,   a_src, ga, inv, a_out));
      r.green = 8'(mix_channel(p.top_green, p.ground_green, a_src, ga, inv, a_out));
      r.blue  = 8'(mix_channel(p.top_blue,  p.ground_blue,  a_src, ga, inv, a_out));
      r.alpha = 8'(a_out);
      return r;
    endfunction

    function void note_pixel(pix_t p);
      expected_pixels.push_back(blend_over(p));
    endfunction

    function void compare_field(string field, logic [7:0] exp_v, logic [7:0] got_v);
      if (got_v !== exp_v) begin
        errors++;
        $display("%0t: result %0d %s mismatch: expected %0d, actual %0d",
                 $time, checked, field, exp_v, got_v);
      end
    endfunction

    function void check_pixel(rgba_t got);
      rgba_t want;
      if (expected_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual %h", $time, got);
        return;
      end
      want = expected_pixels.pop_front();
      compare_field("red",   want.red,   got.red);
      compare_field("green", want.green, got.green);
      compare_field("blue",  want.blue,  got.blue);
      compare_field("alpha", want.alpha, got.alpha);
      checked++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit   calm = 1'b0;      // no idling on either side
  bit   hold_req = 1'b0;  // asks the receiver for a long stall

  blend_scoreboard sb = new();

  rgbaob_in_if  in_if ();
  rgbaob_out_if out_if ();

  rgba_over_blend_intensity_unit i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic set_payload(input pix_t p);
    in_if.top_red      = p.top_red;
    in_if.top_green    = p.top_green;
    in_if.top_blue     = p.top_blue;
    in_if.top_alpha    = p.top_alpha;
    in_if.ground_red   = p.ground_red;
    in_if.ground_green = p.ground_green;
    in_if.ground_blue  = p.ground_blue;
    in_if.ground_alpha = p.ground_alpha;
    in_if.intensity    = p.intensity;
  endtask

  // Offer one item from a falling edge; return at the falling edge after acceptance
  task automatic send_pixel(input pix_t p);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    set_payload(p);
    in_if.valid = 1'b1;
    do @(posedge clk); while (!in_if.ready);
    sb.note_pixel(p);
    @(negedge clk);
  endtask

  task automatic wait_for_drain();
    while (sb.expected_pixels.size() != 0) @(negedge clk);
  endtask

  // Alpha-like values lean toward the edges of the range
  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'(1 + $urandom_range(0, 1) * 253);
      3: return 8'($urandom_range(0, 7));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic pix_t random_pixel();
    pix_t p;
    p.top_red      = ($urandom_range(0, 7) == 0) ? 8'd255 : 8'($urandom_range(0, 255));
    p.top_green    = 8'($urandom_range(0, 255));
    p.top_blue     = 8'($urandom_range(0, 255));
    p.top_alpha    = pick_level();
    p.ground_red   = ($urandom_range(0, 7) == 0) ? 8'd255 : 8'($urandom_range(0, 255));
    p.ground_green = 8'($urandom_range(0, 255));
    p.ground_blue  = 8'($urandom_range(0, 255));
    p.ground_alpha = pick_level();
    p.intensity    = pick_level();
    return p;
  endfunction

  // Stimulus, reset and end of run
  initial begin : pixel_source
    pix_t directed[$];
    in_if.valid = 1'b0;
    set_payload('0);
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // field extremes, transparent, opaque and overflow corners
    directed.push_back(pix_t'{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
    directed.push_back(pix_t'{8'd255, 8'd255, 8'd255, 8'd255,
                              8'd255, 8'd255, 8'd255, 8'd255, 8'd255});
    directed.push_back(pix_t'{8'h55, 8'hAA, 8'h55, 8'hAA, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA});
    directed.push_back(pix_t'{8'hAA, 8'h55, 8'hAA, 8'h55, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55});
    directed.push_back(pix_t'{8'd10, 8'd20, 8'd30, 8'd255, 8'd40, 8'd50, 8'd60, 8'd128, 8'd0});
    directed.push_back(pix_t'{8'd10, 8'd20, 8'd30, 8'd0, 8'd40, 8'd50, 8'd60, 8'd128, 8'd255});
    directed.push_back(pix_t'{8'd99, 8'd1, 8'd200, 8'd1, 8'd7, 8'd8, 8'd9, 8'd255, 8'd254});
    directed.push_back(pix_t'{8'd12, 8'd34, 8'd56, 8'd255, 8'd78, 8'd90, 8'd11, 8'd255, 8'd255});
    directed.push_back(pix_t'{8'd12, 8'd34, 8'd56, 8'd255, 8'd78, 8'd90, 8'd11, 8'd0, 8'd255});
    directed.push_back(pix_t'{8'd12, 8'd34, 8'd56, 8'd255, 8'd78, 8'd90, 8'd11, 8'd255, 8'd254});
    directed.push_back(pix_t'{8'd12, 8'd34, 8'd56, 8'd254, 8'd78, 8'd90, 8'd11, 8'd255, 8'd255});
    directed.push_back(pix_t'{8'd200, 8'd0, 8'd255, 8'd1, 8'd0, 8'd255, 8'd3, 8'd0, 8'd255});
    // channel quotient overflows and saturates
    directed.push_back(pix_t'{8'd255, 8'd255, 8'd255, 8'd1, 8'd255, 8'd255, 8'd255, 8'd1, 8'd255});
    directed.push_back(pix_t'{8'd255, 8'd0, 8'd128, 8'd2, 8'd255, 8'd255, 8'd200, 8'd3, 8'd255});
    directed.push_back(pix_t'{8'd0, 8'd0, 8'd0, 8'd128, 8'd255, 8'd255, 8'd255, 8'd128, 8'd128});
    directed.push_back(pix_t'{8'd255, 8'd255, 8'd255, 8'd128, 8'd0, 8'd0, 8'd0, 8'd255, 8'd128});
    directed.push_back(pix_t'{8'd1, 8'd2, 8'd3, 8'd16, 8'd4, 8'd5, 8'd6, 8'd16, 8'd16});
    foreach (directed[k]) send_pixel(directed[k]);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // long stall at the receiver while items keep coming, then a quiet stretch
      if (n == 120) begin
        calm     = 1'b1;
        hold_req = 1'b1;
      end
      if (n == 220) calm = 1'b0;
      // sender waits until the pipe is empty
      if (n == 300) begin
        in_if.valid = 1'b0;
        wait_for_drain();
        @(negedge clk);
      end
      send_pixel(random_pixel());
    end
    in_if.valid = 1'b0;

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_pixels.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Output ready with random stalls and one long hold-off
  initial begin : pixel_sink
    int unsigned hold_left;
    hold_left    = 0;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        out_if.ready = 1'b0;
        hold_left--;
      end else begin
        out_if.ready = calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Check every accepted result
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_pixel('{out_if.out_red, out_if.out_green, out_if.out_blue, out_if.out_alpha});
  end

  // Hang guard
  initial begin : watchdog
    #200us;
    $display("status: fail");
    $finish;
  end

endmodule

### sim.f
hw/rtl/rgbaob_pkg.sv
hw/rtl/rgbaob_if.sv
hw/rtl/rgbaob_div.sv
hw/rtl/rgba_over_blend_intensity_unit.sv
sim/tb.sv
